// ----- hw/rtl/clipped_line_pixel_generator_unit_defines.svh -----
// assertion macros for the clipped line pixel generator
`ifndef CLIPPED_LINE_PIXEL_GENERATOR_UNIT_DEFINES_SVH
`define CLIPPED_LINE_PIXEL_GENERATOR_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk_i, off while rst_ni is low
`define CLPG_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("clpg check failed");

// next-cycle implication, sampled on clk_i, off while rst_ni is low
`define CLPG_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("clpg check failed");

`endif

// ----- hw/rtl/clpg_pkg.sv -----
// types, constants and helpers shared by the clipped line pixel generator
package clpg_pkg;

  localparam int unsigned CoordBitsDef    = 16;
  localparam int unsigned ColorBits       = 8;
  localparam int unsigned PixelBits       = 16;
  localparam int unsigned CfgIdxBits      = 2;
  // clip reset values need at least this many signed bits
  localparam int unsigned ClipResetBits   = 12;
  localparam int unsigned ClipRightReset  = 1280;
  localparam int unsigned ClipBottomReset = 960;

  typedef enum logic {
    CmdBegin = 1'b0,
    CmdStep  = 1'b1
  } command_e;

  typedef enum logic [1:0] {
    ModeIdle = 2'd0,
    ModeVert = 2'd1,
    ModeHorz = 2'd2,
    ModeBres = 2'd3
  } walk_mode_e;

  typedef enum logic [CfgIdxBits-1:0] {
    CfgClipLeft   = 2'd0,
    CfgClipTop    = 2'd1,
    CfgClipRight  = 2'd2,
    CfgClipBottom = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    walk_mode_e mode;
    logic       neg_x;
    logic       neg_y;
    logic       y_major;
  } walk_ctrl_t;

  function automatic logic [PixelBits-1:0] pack_rgb565(
    input logic [ColorBits-1:0] red,
    input logic [ColorBits-1:0] green,
    input logic [ColorBits-1:0] blue
  );
    return {red[7:3], green[7:2], blue[7:3]};
  endfunction

endpackage

// ----- hw/rtl/clpg_if.sv -----
// request, result and register write channels of the clipped line pixel generator
interface clpg_in_if import clpg_pkg::*; #(
  parameter int unsigned CoordBits = CoordBitsDef
) ();
  logic                        valid;
  logic                        ready;
  logic                        command;
  logic signed [CoordBits-1:0] x_start;
  logic signed [CoordBits-1:0] y_start;
  logic signed [CoordBits-1:0] x_end;
  logic signed [CoordBits-1:0] y_end;
  logic [ColorBits-1:0]        red;
  logic [ColorBits-1:0]        green;
  logic [ColorBits-1:0]        blue;

  modport source (output valid, command, x_start, y_start, x_end, y_end, red, green, blue,
                  input ready);
  modport sink   (input valid, command, x_start, y_start, x_end, y_end, red, green, blue,
                  output ready);
endinterface

interface clpg_out_if import clpg_pkg::*; #(
  parameter int unsigned CoordBits = CoordBitsDef
) ();
  logic                        valid;
  logic                        ready;
  logic signed [CoordBits-1:0] pixel_x;
  logic signed [CoordBits-1:0] pixel_y;
  logic [PixelBits-1:0]        pixel_value;
  logic                        write_enable;
  logic                        last;
  logic                        done_res;

  modport source (output valid, pixel_x, pixel_y, pixel_value, write_enable, last, done_res,
                  input ready);
  modport sink   (input valid, pixel_x, pixel_y, pixel_value, write_enable, last, done_res,
                  output ready);
endinterface

interface clpg_cfg_if import clpg_pkg::*; #(
  parameter int unsigned CoordBits = CoordBitsDef
) ();
  logic                        valid;
  logic                        ready;
  logic [CfgIdxBits-1:0]       index;
  logic signed [CoordBits-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- hw/rtl/clpg_setup.sv -----
// line setup: walk mode, start point, stop coordinate and bresenham terms
module clpg_setup import clpg_pkg::*; #(
  parameter int unsigned CoordBits = CoordBitsDef
) (
  input  logic signed [CoordBits-1:0] x_start_i,
  input  logic signed [CoordBits-1:0] y_start_i,
  input  logic signed [CoordBits-1:0] x_end_i,
  input  logic signed [CoordBits-1:0] y_end_i,
  output logic signed [CoordBits-1:0] cur_x_o,
  output logic signed [CoordBits-1:0] cur_y_o,
  output logic signed [CoordBits-1:0] stop_o,
  output logic signed [CoordBits+3:0] err_o,
  output logic signed [CoordBits+3:0] inc_str_o,
  output logic signed [CoordBits+3:0] inc_diag_o,
  output walk_ctrl_t                  ctrl_o,
  output logic                        empty_o
);

  logic [CoordBits:0]          dx, dy;
  logic [CoordBits:0]          adx, ady, adp, ads;
  logic signed [CoordBits+3:0] adp_e, ads_e;
  logic                        y_major;

  assign dx = {x_end_i[CoordBits-1], x_end_i} - {x_start_i[CoordBits-1], x_start_i};
  assign dy = {y_end_i[CoordBits-1], y_end_i} - {y_start_i[CoordBits-1], y_start_i};

  assign adx     = dx[CoordBits] ? (~dx + 1'b1) : dx;
  assign ady     = dy[CoordBits] ? (~dy + 1'b1) : dy;
  assign y_major = ady > adx;
  assign adp     = y_major ? ady : adx;
  assign ads     = y_major ? adx : ady;

  assign adp_e = $signed({3'b000, adp});
  assign ads_e = $signed({3'b000, ads});

  assign inc_str_o  = ads_e <<< 1;
  assign err_o      = (ads_e <<< 1) - adp_e;
  assign inc_diag_o = (ads_e <<< 1) - (adp_e <<< 1);

  assign empty_o = (dx == '0) && (dy == '0);

  always_comb begin
    ctrl_o.neg_x   = dx[CoordBits];
    ctrl_o.neg_y   = dy[CoordBits];
    ctrl_o.y_major = y_major;
    cur_x_o        = x_start_i;
    cur_y_o        = y_start_i;
    stop_o         = y_major ? y_end_i : x_end_i;
    if (empty_o) begin
      ctrl_o.mode = ModeIdle;
    end else if (dx == '0) begin
      ctrl_o.mode = ModeVert;
      cur_y_o     = (y_start_i < y_end_i) ? y_start_i : y_end_i;
      stop_o      = (y_start_i < y_end_i) ? y_end_i : y_start_i;
    end else if (dy == '0) begin
      ctrl_o.mode = ModeHorz;
      cur_x_o     = (x_start_i < x_end_i) ? x_start_i : x_end_i;
      stop_o      = (x_start_i < x_end_i) ? x_end_i : x_start_i;
    end else begin
      ctrl_o.mode = ModeBres;
    end
  end

endmodule

// ----- hw/rtl/clipped_line_pixel_generator_unit.sv -----
// Clipped line pixel generator top level. A begin request loads two endpoints and a colour
// and answers with one result (done_res set when the endpoints are equal); each step request
// answers with one pixel of the line, write_enable set when it lies inside the half-open clip
// rectangle and last on the final pixel, or with done_res once the line is finished. For every
// request the walk state updates at acceptance and the result lands in an output register, so
// with the result side ready a request is accepted on every clock and a result leaves in the
// cycle after its request. Clip registers are written through the register channel, which is
// always ready, and must only be written while no result is pending.
`include "clipped_line_pixel_generator_unit_defines.svh"

module clipped_line_pixel_generator_unit import clpg_pkg::*; #(
  parameter int unsigned CoordBits = CoordBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  clpg_in_if.sink     in_i,
  clpg_out_if.source  out_o,
  clpg_cfg_if.sink    cfg_i
);

  localparam int unsigned ClipBits = (CoordBits >= ClipResetBits) ? CoordBits : ClipResetBits;
  localparam int unsigned ErrBits  = CoordBits + 4;

  // clip rectangle
  logic signed [ClipBits-1:0] clip_left_q, clip_top_q, clip_right_q, clip_bottom_q;

  // walk state
  logic signed [CoordBits-1:0] cur_x_q, cur_x_d, cur_y_q, cur_y_d, stop_q, stop_d;
  logic signed [ErrBits-1:0]   err_q, err_d, inc_str_q, inc_str_d, inc_diag_q, inc_diag_d;
  walk_ctrl_t                  ctrl_q, ctrl_d;
  logic [PixelBits-1:0]        colour_q, colour_d;

  // result register
  logic                        out_valid_q, out_valid_d;
  logic signed [CoordBits-1:0] out_x_q, out_x_d, out_y_q, out_y_d;
  logic [PixelBits-1:0]        out_value_q, out_value_d;
  logic                        out_we_q, out_we_d, out_last_q, out_last_d, out_done_q, out_done_d;

  // setup
  logic signed [CoordBits-1:0] set_x, set_y, set_stop;
  logic signed [ErrBits-1:0]   set_err, set_inc_str, set_inc_diag;
  walk_ctrl_t                  set_ctrl;
  logic                        set_empty;

  logic                        in_acc, is_begin, in_clip, fin;
  logic signed [ClipBits-1:0]  cx, cy;
  logic [CoordBits:0]          x_inc, y_inc;
  logic signed [CoordBits-1:0] x_step, y_step;

  clpg_setup #(
    .CoordBits (CoordBits)
  ) u_setup (
    .x_start_i  (in_i.x_start),
    .y_start_i  (in_i.y_start),
    .x_end_i    (in_i.x_end),
    .y_end_i    (in_i.y_end),
    .cur_x_o    (set_x),
    .cur_y_o    (set_y),
    .stop_o     (set_stop),
    .err_o      (set_err),
    .inc_str_o  (set_inc_str),
    .inc_diag_o (set_inc_diag),
    .ctrl_o     (set_ctrl),
    .empty_o    (set_empty)
  );

  assign in_i.ready  = !out_valid_q || out_o.ready;
  assign in_acc      = in_i.valid && in_i.ready;
  assign is_begin    = command_e'(in_i.command) == CmdBegin;
  assign cfg_i.ready = 1'b1;

  assign cx      = ClipBits'(cur_x_q);
  assign cy      = ClipBits'(cur_y_q);
  assign in_clip = (cx >= clip_left_q) && (cx < clip_right_q) &&
                   (cy >= clip_top_q) && (cy < clip_bottom_q);

  // one wider so the straight-walk end test cannot wrap
  assign x_inc  = {cur_x_q[CoordBits-1], cur_x_q} + 1'b1;
  assign y_inc  = {cur_y_q[CoordBits-1], cur_y_q} + 1'b1;
  assign x_step = ctrl_q.neg_x ? (cur_x_q - 1'b1) : (cur_x_q + 1'b1);
  assign y_step = ctrl_q.neg_y ? (cur_y_q - 1'b1) : (cur_y_q + 1'b1);

  always_comb begin
    cur_x_d    = cur_x_q;
    cur_y_d    = cur_y_q;
    stop_d     = stop_q;
    err_d      = err_q;
    inc_str_d  = inc_str_q;
    inc_diag_d = inc_diag_q;
    ctrl_d     = ctrl_q;
    colour_d   = colour_q;
    fin        = 1'b0;
    out_x_d     = '0;
    out_y_d     = '0;
    out_value_d = '0;
    out_we_d    = 1'b0;
    out_last_d  = 1'b0;
    out_done_d  = 1'b0;
    if (is_begin) begin
      cur_x_d    = set_x;
      cur_y_d    = set_y;
      stop_d     = set_stop;
      err_d      = set_err;
      inc_str_d  = set_inc_str;
      inc_diag_d = set_inc_diag;
      ctrl_d     = set_ctrl;
      colour_d   = pack_rgb565(in_i.red, in_i.green, in_i.blue);
      out_done_d = set_empty;
    end else if (ctrl_q.mode == ModeIdle) begin
      out_done_d = 1'b1;
    end else begin
      unique case (ctrl_q.mode)
        ModeVert: begin
          fin     = y_inc == {stop_q[CoordBits-1], stop_q};
          cur_y_d = y_inc[CoordBits-1:0];
        end
        ModeHorz: begin
          fin     = x_inc == {stop_q[CoordBits-1], stop_q};
          cur_x_d = x_inc[CoordBits-1:0];
        end
        default: begin
          fin = ctrl_q.y_major ? (cur_y_q == stop_q) : (cur_x_q == stop_q);
          if (!fin) begin
            if (!err_q[ErrBits-1]) begin
              err_d = err_q + inc_diag_q;
              if (ctrl_q.y_major) begin
                cur_x_d = x_step;
              end else begin
                cur_y_d = y_step;
              end
            end else begin
              err_d = err_q + inc_str_q;
            end
            if (ctrl_q.y_major) begin
              cur_y_d = y_step;
            end else begin
              cur_x_d = x_step;
            end
          end
        end
      endcase
      if (fin) begin
        ctrl_d.mode = ModeIdle;
      end
      out_x_d     = cur_x_q;
      out_y_d     = cur_y_q;
      out_value_d = colour_q;
      out_we_d    = in_clip;
      out_last_d  = fin;
    end
  end

  assign out_valid_d = in_i.ready ? in_i.valid : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q      <= '{mode: ModeIdle, neg_x: 1'b0, neg_y: 1'b0, y_major: 1'b0};
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (in_acc) begin
        ctrl_q <= ctrl_d;
      end
    end
  end

  // walk state is zero after reset like the rest of the line state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_x_q    <= '0;
      cur_y_q    <= '0;
      stop_q     <= '0;
      err_q      <= '0;
      inc_str_q  <= '0;
      inc_diag_q <= '0;
      colour_q   <= '0;
    end else if (in_acc) begin
      cur_x_q    <= cur_x_d;
      cur_y_q    <= cur_y_d;
      stop_q     <= stop_d;
      err_q      <= err_d;
      inc_str_q  <= inc_str_d;
      inc_diag_q <= inc_diag_d;
      colour_q   <= colour_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      out_x_q     <= out_x_d;
      out_y_q     <= out_y_d;
      out_value_q <= out_value_d;
      out_we_q    <= out_we_d;
      out_last_q  <= out_last_d;
      out_done_q  <= out_done_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clip_left_q   <= '0;
      clip_top_q    <= '0;
      clip_right_q  <= ClipBits'(ClipRightReset);
      clip_bottom_q <= ClipBits'(ClipBottomReset);
    end else if (cfg_i.valid && cfg_i.ready) begin
      unique case (cfg_reg_e'(cfg_i.index))
        CfgClipLeft:   clip_left_q   <= ClipBits'(cfg_i.data);
        CfgClipTop:    clip_top_q    <= ClipBits'(cfg_i.data);
        CfgClipRight:  clip_right_q  <= ClipBits'(cfg_i.data);
        CfgClipBottom: clip_bottom_q <= ClipBits'(cfg_i.data);
        default: ;
      endcase
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.pixel_x      = out_x_q;
  assign out_o.pixel_y      = out_y_q;
  assign out_o.pixel_value  = out_value_q;
  assign out_o.write_enable = out_we_q;
  assign out_o.last         = out_last_q;
  assign out_o.done_res     = out_done_q;

  // a done result never carries a pixel
  `CLPG_ASSERT_IMPL(a_done_no_pixel, out_valid_q && out_done_q, !out_we_q && !out_last_q)
  // a begin leaves the walk idle exactly when it reports an empty line
  `CLPG_ASSERT_NEXT(a_begin_idle, in_acc && is_begin,
                    out_valid_q && ((ctrl_q.mode == ModeIdle) == out_done_q))
  // a pixel step ends the walk exactly when it flags last
  `CLPG_ASSERT_NEXT(a_last_idle, in_acc && !is_begin && (ctrl_q.mode != ModeIdle),
                    out_last_q == (ctrl_q.mode == ModeIdle))
  // a step on an idle walk keeps it idle and reports done
  `CLPG_ASSERT_NEXT(a_idle_step, in_acc && !is_begin && (ctrl_q.mode == ModeIdle),
                    out_done_q && (ctrl_q.mode == ModeIdle))

endmodule

// ----- tb/clipped_line_pixel_generator_unit_test.sv -----
// self-checking testbench for the clipped line pixel generator: line walks against a predictor
`timescale 1ns / 1ps

module clipped_line_pixel_generator_unit_test;
  import clpg_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned HOLD_CYCLES = 300;

  typedef struct packed {
    command_e    cmd;
    logic [15:0] xs;
    logic [15:0] ys;
    logic [15:0] xe;
    logic [15:0] ye;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
  } line_req_t;

  typedef struct packed {
    logic [15:0] px;
    logic [15:0] py;
    logic [15:0] value;
    logic        we;
    logic        last;
    logic        done;
  } pixel_t;

  class line_scoreboard;
    longint     clip_l, clip_t, clip_r, clip_b;
    longint     cx, cy, stop_at, err, inc_s, inc_d;
    walk_mode_e mode;
    logic       neg_x, neg_y, y_major;
    logic [15:0] colour;
    pixel_t     pending_q[$];
    int unsigned errors;

    function new();
      clip_l = 0;
      clip_t = 0;
      clip_r = ClipRightReset;
      clip_b = ClipBottomReset;
      cx = 0;
      cy = 0;
      stop_at = 0;
      err = 0;
      inc_s = 0;
      inc_d = 0;
      mode = ModeIdle;
      neg_x = 1'b0;
      neg_y = 1'b0;
      y_major = 1'b0;
      colour = '0;
      errors = 0;
    endfunction

    function void set_clip(cfg_reg_e idx, logic signed [15:0] v);
      case (idx)
        CfgClipLeft:   clip_l = v;
        CfgClipTop:    clip_t = v;
        CfgClipRight:  clip_r = v;
        CfgClipBottom: clip_b = v;
        default: ;
      endcase
    endfunction

    function void note_request(line_req_t rq);
      pixel_t res;
      longint x1, y1, x2, y2, dx, dy, adx, ady, major, minor, sx, sy;
      bit fin;
      res = '0;
      if (rq.cmd == CmdBegin) begin
        x1 = $signed(rq.xs);
        y1 = $signed(rq.ys);
        x2 = $signed(rq.xe);
        y2 = $signed(rq.ye);
        dx = x2 - x1;
        dy = y2 - y1;
        colour = {rq.red[7:3], rq.green[7:2], rq.blue[7:3]};
        err = 0;
        inc_s = 0;
        inc_d = 0;
        neg_x = 1'b0;
        neg_y = 1'b0;
        y_major = 1'b0;
        if (dx == 0 && dy == 0) begin
          mode = ModeIdle;
          res.done = 1'b1;
        end else if (dx == 0) begin
          mode = ModeVert;
          cx = x1;
          cy = (y1 < y2) ? y1 : y2;
          stop_at = (y1 < y2) ? y2 : y1;
        end else if (dy == 0) begin
          mode = ModeHorz;
          cy = y1;
          cx = (x1 < x2) ? x1 : x2;
          stop_at = (x1 < x2) ? x2 : x1;
        end else begin
          mode = ModeBres;
          cx = x1;
          cy = y1;
          neg_x = dx < 0;
          neg_y = dy < 0;
          adx = (dx < 0) ? -dx : dx;
          ady = (dy < 0) ? -dy : dy;
          if (adx >= ady) begin
            major = adx;
            minor = ady;
            stop_at = x2;
          end else begin
            major = ady;
            minor = adx;
            stop_at = y2;
            y_major = 1'b1;
          end
          inc_s = 2 * minor;
          err = 2 * minor - major;
          inc_d = 2 * minor - 2 * major;
        end
      end else if (mode == ModeIdle) begin
        res.done = 1'b1;
      end else begin
        res.px = cx[15:0];
        res.py = cy[15:0];
        res.value = colour;
        res.we = cx >= clip_l && cx < clip_r && cy >= clip_t && cy < clip_b;
        case (mode)
          ModeVert: begin
            fin = (cy + 1 == stop_at);
            cy += 1;
          end
          ModeHorz: begin
            fin = (cx + 1 == stop_at);
            cx += 1;
          end
          default: begin
            sx = neg_x ? -1 : 1;
            sy = neg_y ? -1 : 1;
            fin = y_major ? (cy == stop_at) : (cx == stop_at);
            if (!fin) begin
              // diagonal move when the decision term is not negative
              if (err >= 0) begin
                if (y_major) cx += sx;
                else cy += sy;
                err += inc_d;
              end else begin
                err += inc_s;
              end
              if (y_major) cy += sy;
              else cx += sx;
            end
          end
        endcase
        if (fin) mode = ModeIdle;
        res.last = fin;
      end
      pending_q.push_back(res);
    endfunction

    task report_mismatch(string what);
      if (errors < 40) $display("[%0t] mismatch: %s", $realtime, what);
      errors++;
    endtask

    task check_result(pixel_t got);
      pixel_t want;
      if (pending_q.size() == 0) begin
        report_mismatch("result arrived with no request waiting");
        return;
      end
      want = pending_q.pop_front();
      if (got.px !== want.px)
        report_mismatch($sformatf("pixel_x got %0d expected %0d",
                                  $signed(got.px), $signed(want.px)));
      if (got.py !== want.py)
        report_mismatch($sformatf("pixel_y got %0d expected %0d",
                                  $signed(got.py), $signed(want.py)));
      if (got.value !== want.value)
        report_mismatch($sformatf("pixel_value got %h expected %h", got.value, want.value));
      if (got.we !== want.we)
        report_mismatch($sformatf("write_enable got %b expected %b at (%0d,%0d)",
                                  got.we, want.we, $signed(want.px), $signed(want.py)));
      if (got.last !== want.last)
        report_mismatch($sformatf("last got %b expected %b", got.last, want.last));
      if (got.done !== want.done)
        report_mismatch($sformatf("done_res got %b expected %b", got.done, want.done));
    endtask
  endclass

  logic clk_i;
  logic rst_ni;
  bit   no_idle;
  bit   hold_results;
  int unsigned hold_count;
  int unsigned sent_count;
  int unsigned cycle_count;
  line_scoreboard sb = new();

  clpg_in_if  #(.CoordBits(16)) in_ch ();
  clpg_out_if #(.CoordBits(16)) out_ch ();
  clpg_cfg_if #(.CoordBits(16)) cfg_ch ();

  clipped_line_pixel_generator_unit #(.CoordBits(16)) u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch),
    .cfg_i  (cfg_ch)
  );

  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // request side first so a same-edge result never overtakes its request
  always @(posedge clk_i) begin
    line_req_t rq;
    pixel_t    got;
    if (rst_ni) begin
      if (in_ch.valid && in_ch.ready) begin
        rq.cmd   = command_e'(in_ch.command);
        rq.xs    = in_ch.x_start;
        rq.ys    = in_ch.y_start;
        rq.xe    = in_ch.x_end;
        rq.ye    = in_ch.y_end;
        rq.red   = in_ch.red;
        rq.green = in_ch.green;
        rq.blue  = in_ch.blue;
        sb.note_request(rq);
      end
      if (out_ch.valid && out_ch.ready) begin
        got.px    = out_ch.pixel_x;
        got.py    = out_ch.pixel_y;
        got.value = out_ch.pixel_value;
        got.we    = out_ch.write_enable;
        got.last  = out_ch.last;
        got.done  = out_ch.done_res;
        sb.check_result(got);
      end
    end
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin
    out_ch.ready = 1'b0;
    hold_count = 0;
    forever begin
      @(posedge clk_i);
      if (hold_count != 0) begin
        out_ch.ready <= 1'b0;
        hold_count--;
      end else if (hold_results) begin
        out_ch.ready <= 1'b0;
        hold_count = HOLD_CYCLES;
        hold_results <= 1'b0;
      end else begin
        out_ch.ready <= no_idle || ($urandom_range(99) >= 10);
      end
    end
  end

  function automatic int clamp_coord(int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  // far endpoint; mirrored when it would leave the coordinate range
  function automatic int end_coord(int base, int delta);
    int v;
    v = base + delta;
    if (v > 32767 || v < -32768) v = base - delta;
    return v;
  endfunction

  function automatic line_req_t random_request(command_e cmd);
    line_req_t rq;
    rq.cmd   = cmd;
    rq.xs    = 16'($urandom);
    rq.ys    = 16'($urandom);
    rq.xe    = 16'($urandom);
    rq.ye    = 16'($urandom);
    rq.red   = 8'($urandom);
    rq.green = 8'($urandom);
    rq.blue  = 8'($urandom);
    return rq;
  endfunction

  task automatic send_request(line_req_t rq);
    in_ch.valid   <= 1'b1;
    in_ch.command <= rq.cmd;
    in_ch.x_start <= rq.xs;
    in_ch.y_start <= rq.ys;
    in_ch.x_end   <= rq.xe;
    in_ch.y_end   <= rq.ye;
    in_ch.red     <= rq.red;
    in_ch.green   <= rq.green;
    in_ch.blue    <= rq.blue;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    sent_count++;
    if (!no_idle && $urandom_range(99) < 10) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
  endtask

  task automatic send_step();
    send_request(random_request(CmdStep));
  endtask

  task automatic send_begin(int xs, int ys, int xe, int ye, int r, int g, int b);
    line_req_t rq;
    rq.cmd   = CmdBegin;
    rq.xs    = 16'(xs);
    rq.ys    = 16'(ys);
    rq.xe    = 16'(xe);
    rq.ye    = 16'(ye);
    rq.red   = 8'(r);
    rq.green = 8'(g);
    rq.blue  = 8'(b);
    send_request(rq);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic program_clip(longint l, longint t, longint r, longint b);
    cfg_reg_e regs[4];
    longint   vals[4];
    regs = '{CfgClipLeft, CfgClipTop, CfgClipRight, CfgClipBottom};
    vals = '{l, t, r, b};
    for (int i = 0; i < 4; i++) begin
      cfg_ch.valid <= 1'b1;
      cfg_ch.index <= regs[i];
      cfg_ch.data  <= vals[i][15:0];
      @(posedge clk_i);
      while (!cfg_ch.ready) @(posedge clk_i);
      sb.set_clip(regs[i], vals[i][15:0]);
    end
    cfg_ch.valid <= 1'b0;
  endtask

  // one begin with its pixel requests; a share is noise or cut short
  task automatic random_sequence();
    line_req_t rq;
    int pick, shape, reach, dxm, dym, n_pix, n_steps;
    int x1, y1, x2, y2;
    pick = $urandom_range(99);
    if (pick < 8) begin
      send_step();
      return;
    end
    if (pick < 14) begin
      send_request(random_request(CmdBegin));
      repeat ($urandom_range(0, 3)) send_step();
      return;
    end
    if ($urandom_range(1) == 1) begin
      x1 = clamp_coord(int'(sb.clip_l) - 6 + $urandom_range(0, 30));
      y1 = clamp_coord(int'(sb.clip_t) - 6 + $urandom_range(0, 30));
    end else begin
      x1 = $signed(16'($urandom));
      y1 = $signed(16'($urandom));
    end
    reach = ($urandom_range(19) == 0) ? 300 : 24;
    dxm = $urandom_range(1, reach);
    dym = $urandom_range(1, reach);
    if ($urandom_range(1) == 1) dxm = -dxm;
    if ($urandom_range(1) == 1) dym = -dym;
    shape = $urandom_range(99);
    if (shape < 15) begin
      x2 = x1;
      y2 = end_coord(y1, dym);
      n_pix = (y2 > y1) ? y2 - y1 : y1 - y2;
    end else if (shape < 30) begin
      y2 = y1;
      x2 = end_coord(x1, dxm);
      n_pix = (x2 > x1) ? x2 - x1 : x1 - x2;
    end else if (shape < 34) begin
      x2 = x1;
      y2 = y1;
      n_pix = 0;
    end else begin
      if (shape < 40) dym = (dym < 0) == (dxm < 0) ? dxm : -dxm;
      x2 = end_coord(x1, dxm);
      y2 = end_coord(y1, dym);
      dxm = (x2 > x1) ? x2 - x1 : x1 - x2;
      dym = (y2 > y1) ? y2 - y1 : y1 - y2;
      n_pix = ((dxm > dym) ? dxm : dym) + 1;
    end
    rq = random_request(CmdBegin);
    rq.xs = 16'(x1);
    rq.ys = 16'(y1);
    rq.xe = 16'(x2);
    rq.ye = 16'(y2);
    send_request(rq);
    n_steps = n_pix + $urandom_range(0, 2);
    if ($urandom_range(9) == 0) n_steps = $urandom_range(0, n_pix);
    repeat (n_steps) send_step();
  endtask

  task automatic run_until(int unsigned target);
    while (sent_count < target) random_sequence();
  endtask

  initial begin
    rst_ni          = 1'b0;
    no_idle         = 1'b0;
    hold_results    = 1'b0;
    sent_count      = 0;
    cycle_count     = 0;
    in_ch.valid     = 1'b0;
    in_ch.command   = CmdStep;
    in_ch.x_start   = '0;
    in_ch.y_start   = '0;
    in_ch.x_end     = '0;
    in_ch.y_end     = '0;
    in_ch.red       = '0;
    in_ch.green     = '0;
    in_ch.blue      = '0;
    cfg_ch.valid    = 1'b0;
    cfg_ch.index    = CfgClipLeft;
    cfg_ch.data     = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed lines under the reset clip window
    send_step();
    send_begin(5, 5, 5, 5, 0, 0, 0);
    send_step();
    send_begin(3, 10, 3, 8, 255, 255, 255);
    repeat (3) send_step();
    send_begin(-2, 4, 1, 4, 8, 4, 8);
    repeat (3) send_step();
    send_begin(0, 0, -1, -3, 200, 100, 50);
    repeat (4) send_step();
    send_begin(1279, 958, 1284, 961, 7, 3, 7);
    repeat (2) send_step();
    send_begin(-32768, -32768, 32767, 32767, 255, 0, 255);
    repeat (2) send_step();
    send_begin(32767, 32767, 32767, -32768, 0, 255, 0);
    send_step();
    run_until(200);

    drain();
    program_clip(-5, -5, 20, 12);
    run_until(400);

    // full range window; the result side holds off while requests keep coming
    drain();
    program_clip(-32768, -32768, 32767, 32767);
    hold_results <= 1'b1;
    run_until(600);

    // inverted width, zero height
    drain();
    program_clip(100, 50, 90, 50);
    run_until(750);

    drain();
    program_clip(-300 + $urandom_range(0, 300), -300 + $urandom_range(0, 300),
                 $urandom_range(1, 400), $urandom_range(1, 400));
    run_until(900);
    drain();
    run_until(1000);

    drain();
    no_idle = 1'b1;
    program_clip(32700, -32768, 32767, -32700);
    run_until(1200);
    drain();
    no_idle = 1'b0;

    program_clip($signed(16'($urandom)), $signed(16'($urandom)),
                 $signed(16'($urandom)), $signed(16'($urandom)));
    run_until(1400);

    drain();
    repeat (10) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending_q.size() == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule
